### hw/rtl/ogf_pkg.sv
// Shared package for the oriented Gaussian field value block.
// Holds payload and configuration types, fixed-point constants and the exp2 table.
// No dependencies; every other RTL file imports it.
`default_nettype none

package ogf_pkg;

  // Defaults for top-level parameters
  localparam int CORDIC_STEPS_DEF   = 24;
  localparam int EXP_TABLE_BITS_DEF = 8;
  localparam int FIFO_DEPTH_DEF     = 4;

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X     = 3'd0,
    REG_CENTRE_Y     = 3'd1,
    REG_VELOCITY_X   = 3'd2,
    REG_VELOCITY_Y   = 3'd3,
    REG_SIGMA_ALONG  = 3'd4,
    REG_SIGMA_ACROSS = 3'd5
  } cfg_reg_t;

  // Datapath widths
  localparam int CW        = 36;          // rotation datapath
  localparam int DVD_W     = CW + 16;     // ratio dividend (magnitude << 16)
  localparam int RATIO_QB  = 22;          // ratio quotient bits resolved
  localparam int RATIO_W   = 21;          // clamped ratio width
  localparam int TRIAL_W   = 32 + RATIO_QB;
  localparam int NUM_W     = 60;          // density numerator
  localparam int QDEN_W    = 32;          // density quotient bits
  localparam int QWIDE_W   = NUM_W + QDEN_W;

  localparam logic [RATIO_W-1:0] RATIO_MAX     = 21'h100000;   // 16.0
  localparam logic [23:0]        GAIN_INV_Q24  = 24'd10187995;
  localparam logic [30:0]        LOG2E_Q30     = 31'd1549082005;
  localparam logic [29:0]        INV2PI_Q32    = 30'd683565276;
  localparam logic [15:0]        LN2_Q16       = 16'd45426;
  localparam logic [30:0]        ONE_Q30       = 31'h40000000;

  typedef struct packed {
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic [31:0] density;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] centre_x;
    logic signed [31:0] centre_y;
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic        [31:0] sigma_along;
    logic        [31:0] sigma_across;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic               vzero;
  } work_t;

  // 2^-(2^-(j+1)) in Q30
  function automatic logic [29:0] pow2_frac(input logic [3:0] j);
    logic [29:0] c;
    case (j)
      4'd0:    c = 30'd759250125;
      4'd1:    c = 30'd902905651;
      4'd2:    c = 30'd984625594;
      4'd3:    c = 30'd1028218693;
      4'd4:    c = 30'd1050733751;
      4'd5:    c = 30'd1062175491;
      4'd6:    c = 30'd1067942999;
      4'd7:    c = 30'd1070838486;
      4'd8:    c = 30'd1072289173;
      4'd9:    c = 30'd1073015252;
      4'd10:   c = 30'd1073378477;
      4'd11:   c = 30'd1073560135;
      default: c = 30'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ogf_front.sv
// Front stage: accept a query, offset it from the centre and fold the heading.
// Depends on ogf_pkg.
`default_nettype none

module ogf_front import ogf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  input  cfg_t     cfg,
  input  logic     q_full,
  output logic     q_push,
  output work_t    q_item
);

  logic               valid_r;
  work_t              item_r;
  work_t              item_nxt;
  logic signed [32:0] dx;
  logic signed [32:0] dy;

  always_comb begin
    dx = {in_data.query_x[31], in_data.query_x} - {cfg.centre_x[31], cfg.centre_x};
    dy = {in_data.query_y[31], in_data.query_y} - {cfg.centre_y[31], cfg.centre_y};
    item_nxt.vzero = (cfg.velocity_x == 32'sd0) && (cfg.velocity_y == 32'sd0);
    // Turn by half a circle when the heading points to negative x
    if (cfg.velocity_x[31]) begin
      item_nxt.x  = -{dx[32], dx};
      item_nxt.y  = -{dy[32], dy};
      item_nxt.vx = -{cfg.velocity_x[31], cfg.velocity_x};
      item_nxt.vy = -{cfg.velocity_y[31], cfg.velocity_y};
    end else begin
      item_nxt.x  = {dx[32], dx};
      item_nxt.y  = {dy[32], dy};
      item_nxt.vx = {cfg.velocity_x[31], cfg.velocity_x};
      item_nxt.vy = {cfg.velocity_y[31], cfg.velocity_y};
    end
  end

  assign in_stall = valid_r && q_full;
  assign q_push   = valid_r && !q_full;
  assign q_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ogf_fifo.sv
// Short queue decoupling the front stage from the arithmetic back end.
// Depends on ogf_pkg.
`default_nettype none

module ogf_fifo import ogf_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  work_t din,
  output logic  full,
  input  logic  pop,
  output work_t dout,
  output logic  empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  work_t           mem_r [DEPTH];
  logic [AW-1:0]   wp_r;
  logic [AW-1:0]   rp_r;
  logic [CNTW-1:0] cnt_r;

  assign full  = (cnt_r == CNTW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CNTW'(push) - CNTW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ogf_rdiv.sv
// Pipelined restoring divider for the offset-to-sigma ratio, one quotient bit per stage.
// Clamps the ratio at 16.0. Depends on ogf_pkg.
`default_nettype none

module ogf_rdiv import ogf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [CW-1:0]      mag,
  input  logic [31:0]        sg,
  output logic               out_vld,
  output logic [RATIO_W-1:0] ratio
);

  typedef struct packed {
    logic [DVD_W-1:0]    rem;
    logic [RATIO_QB-1:0] q;
    logic                ovf;
  } dstage_t;

  dstage_t           st_r [RATIO_QB+1];
  logic [RATIO_QB:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[RATIO_QB-1:0], in_vld};
    end
  end

  // Flag quotients that cannot fit the resolved bits
  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].rem <= {mag, 16'b0};
      st_r[0].q   <= '0;
      st_r[0].ovf <= (mag[CW-1:6] >= sg);
    end
  end

  for (genvar j = 0; j < RATIO_QB; j++) begin : g_bit
    localparam int K = RATIO_QB - 1 - j;
    dstage_t            nx;
    logic [TRIAL_W-1:0] sk;

    always_comb begin
      nx = st_r[j];
      sk = TRIAL_W'(sg) << K;
      if (TRIAL_W'(st_r[j].rem) >= sk) begin
        nx.rem  = st_r[j].rem - sk[DVD_W-1:0];
        nx.q[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_r[j+1] <= nx;
      end
    end
  end

  assign out_vld = vld_r[RATIO_QB];
  assign ratio   = (st_r[RATIO_QB].ovf || (st_r[RATIO_QB].q > {1'b0, RATIO_MAX}))
                   ? RATIO_MAX : st_r[RATIO_QB].q[RATIO_W-1:0];

endmodule

`default_nettype wire

### hw/rtl/ogf_back.sv
// Back end: CORDIC rotation, ratio squares, exp2 evaluation and density division.
// Depends on ogf_pkg and ogf_rdiv.
`default_nettype none

module ogf_back import ogf_pkg::*; #(
  parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      q_empty,
  input  work_t     q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int RW = 16 - EXP_TABLE_BITS;
  localparam int PW = 31 + RW;

  logic adv;
  logic out_valid_r;
  out_item_t out_data_r;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  // Effective spreads and their product
  logic [31:0] sa;
  logic [31:0] sc;
  logic [63:0] d_r;

  assign sa = (cfg.sigma_along  == '0) ? 32'd1 : cfg.sigma_along;
  assign sc = (cfg.sigma_across == '0) ? 32'd1 : cfg.sigma_across;

  always_ff @(posedge clk) begin
    d_r <= 64'(sa) * 64'(sc);
  end

  // ---------------- CORDIC vectoring, offset rotated in lockstep
  typedef struct packed {
    logic                 vz;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
  } cstage_t;

  cstage_t             cs_r [CORDIC_STEPS+1];
  logic [CORDIC_STEPS:0] cv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r <= '0;
    end else if (adv) begin
      cv_r <= {cv_r[CORDIC_STEPS-1:0], !q_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cs_r[0].vz <= q_item.vzero;
      cs_r[0].x  <= {{(CW-34){q_item.x[33]}}, q_item.x};
      cs_r[0].y  <= {{(CW-34){q_item.y[33]}}, q_item.y};
      cs_r[0].vx <= {{(CW-33){q_item.vx[32]}}, q_item.vx};
      cs_r[0].vy <= {{(CW-33){q_item.vy[32]}}, q_item.vy};
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    cstage_t nx;

    always_comb begin
      nx = cs_r[i];
      // Hold the offset unrotated for a zero heading
      if (!cs_r[i].vz) begin
        if (!cs_r[i].vy[CW-1]) begin
          nx.vx = cs_r[i].vx + (cs_r[i].vy >>> i);
          nx.vy = cs_r[i].vy - (cs_r[i].vx >>> i);
          nx.x  = cs_r[i].x  + (cs_r[i].y  >>> i);
          nx.y  = cs_r[i].y  - (cs_r[i].x  >>> i);
        end else begin
          nx.vx = cs_r[i].vx - (cs_r[i].vy >>> i);
          nx.vy = cs_r[i].vy + (cs_r[i].vx >>> i);
          nx.x  = cs_r[i].x  - (cs_r[i].y  >>> i);
          nx.y  = cs_r[i].y  + (cs_r[i].x  >>> i);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        cs_r[i+1] <= nx;
      end
    end
  end

  // ---------------- gain correction
  logic                    g1_vld_r;
  logic                    g1_z_r;
  logic signed [CW-1:0]    g1_x_r;
  logic signed [CW-1:0]    g1_y_r;
  logic signed [CW+24:0]   g1_pu_r;
  logic signed [CW+24:0]   g1_pv_r;
  logic signed [CW+24:0]   gpu;
  logic signed [CW+24:0]   gpv;
  logic signed [CW+24:0]   gsu;
  logic signed [CW+24:0]   gsv;
  logic signed [CW-1:0]    ur;
  logic signed [CW-1:0]    vr;
  logic                    g2_vld_r;
  logic [CW-1:0]           mu_r;
  logic [CW-1:0]           mv_r;

  assign gpu = cs_r[CORDIC_STEPS].x * $signed({1'b0, GAIN_INV_Q24});
  assign gpv = cs_r[CORDIC_STEPS].y * $signed({1'b0, GAIN_INV_Q24});

  always_comb begin
    gsu = g1_pu_r + $signed({{(CW+1){1'b0}}, 1'b1, 23'b0});
    gsv = g1_pv_r + $signed({{(CW+1){1'b0}}, 1'b1, 23'b0});
    ur  = g1_z_r ? g1_x_r : $signed(gsu[24 +: CW]);
    vr  = g1_z_r ? g1_y_r : $signed(gsv[24 +: CW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
      g2_vld_r <= 1'b0;
    end else if (adv) begin
      g1_vld_r <= cv_r[CORDIC_STEPS];
      g2_vld_r <= g1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g1_z_r  <= cs_r[CORDIC_STEPS].vz;
      g1_x_r  <= cs_r[CORDIC_STEPS].x;
      g1_y_r  <= cs_r[CORDIC_STEPS].y;
      g1_pu_r <= gpu;
      g1_pv_r <= gpv;
      mu_r    <= ur[CW-1] ? $unsigned(-ur) : $unsigned(ur);
      mv_r    <= vr[CW-1] ? $unsigned(-vr) : $unsigned(vr);
    end
  end

  // ---------------- ratios
  logic               ru_vld;
  logic               rv_vld;
  logic [RATIO_W-1:0] ru;
  logic [RATIO_W-1:0] rv;

  ogf_rdiv u_rdiv_along (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (g2_vld_r),
    .mag     (mu_r),
    .sg      (sa),
    .out_vld (ru_vld),
    .ratio   (ru)
  );

  ogf_rdiv u_rdiv_across (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (g2_vld_r),
    .mag     (mv_r),
    .sg      (sc),
    .out_vld (rv_vld),
    .ratio   (rv)
  );

  // ---------------- half squares, exponent and log2(e) scaling
  logic [2*RATIO_W-1:0] squ;
  logic [2*RATIO_W-1:0] sqv;
  logic                 sq_vld_r;
  logic [23:0]          qu_r;
  logic [23:0]          qv_r;
  logic                 e_vld_r;
  logic [24:0]          e_r;
  logic                 tp_vld_r;
  logic [55:0]          tp_r;
  logic [55:0]          tsum;

  assign squ  = 42'(ru) * 42'(ru);
  assign sqv  = 42'(rv) * 42'(rv);
  assign tsum = tp_r + (56'd1 << 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      e_vld_r  <= 1'b0;
      tp_vld_r <= 1'b0;
    end else if (adv) begin
      sq_vld_r <= ru_vld && rv_vld;
      e_vld_r  <= sq_vld_r;
      tp_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qu_r <= squ[40:17];
      qv_r <= sqv[40:17];
      e_r  <= 25'(qu_r) + 25'(qv_r);
      tp_r <= 56'(e_r) * 56'(LOG2E_Q30);
    end
  end

  // ---------------- exp2 of the fraction, one table bit per stage
  typedef struct packed {
    logic [30:0] m;
    logic [15:0] fr;
    logic [9:0]  n;
  } estage_t;

  estage_t               ex_r [EXP_TABLE_BITS+1];
  logic [EXP_TABLE_BITS:0] ev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= '0;
    end else if (adv) begin
      ev_r <= {ev_r[EXP_TABLE_BITS-1:0], tp_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ex_r[0].m  <= ONE_Q30;
      ex_r[0].fr <= tsum[45:30];
      ex_r[0].n  <= tsum[55:46];
    end
  end

  for (genvar j = 0; j < EXP_TABLE_BITS; j++) begin : g_exp
    estage_t     nx;
    logic [60:0] prod;
    logic [60:0] rsum;

    always_comb begin
      nx   = ex_r[j];
      prod = 61'(ex_r[j].m) * 61'(pow2_frac(4'(j)));
      rsum = prod + (61'd1 << 29);
      if (ex_r[j].fr[15-j]) begin
        nx.m = rsum[60:30];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ex_r[j+1] <= nx;
      end
    end
  end

  // ---------------- linear correction on the leftover fraction bits
  logic          c1_vld_r;
  logic [PW-1:0] c1_p_r;
  logic [30:0]   c1_m_r;
  logic [9:0]    c1_n_r;
  logic [62:0]   csum;
  logic          c2_vld_r;
  logic [30:0]   c2_m_r;
  logic [9:0]    c2_n_r;

  assign csum = 63'(c1_p_r) * 63'(LN2_Q16) + (63'd1 << 31);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_vld_r <= 1'b0;
      c2_vld_r <= 1'b0;
    end else if (adv) begin
      c1_vld_r <= ev_r[EXP_TABLE_BITS];
      c2_vld_r <= c1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_p_r <= PW'(ex_r[EXP_TABLE_BITS].m) * PW'(ex_r[EXP_TABLE_BITS].fr[RW-1:0]);
      c1_m_r <= ex_r[EXP_TABLE_BITS].m;
      c1_n_r <= ex_r[EXP_TABLE_BITS].n;
      c2_m_r <= c1_m_r - csum[62:32];
      c2_n_r <= c1_n_r;
    end
  end

  // ---------------- numerator and shifted denominator
  logic              np_vld_r;
  logic [NUM_W-1:0]  np_r;
  logic [9:0]        np_n_r;
  logic [60:0]       nprod;
  logic [10:0]       shf;
  logic [6:0]        ramt;
  logic              big;
  logic [63:0]       dpw;
  logic              pp_vld_r;
  logic [NUM_W-1:0]  pp_n_r;
  logic [NUM_W-1:0]  pp_dp_r;
  logic              pp_zero_r;

  assign nprod = 61'(c2_m_r) * 61'(INV2PI_Q32);

  always_comb begin
    shf  = 11'(np_n_r) + 11'd14;
    ramt = 7'd60 - 7'(shf[5:0]);
    // The quotient is zero once the shifted denominator passes the numerator range
    big  = (shf >= 11'd60) || ((d_r >> ramt) != 64'd0);
    dpw  = d_r << shf[5:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      np_vld_r <= 1'b0;
      pp_vld_r <= 1'b0;
    end else if (adv) begin
      np_vld_r <= c2_vld_r;
      pp_vld_r <= np_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      np_r      <= nprod[NUM_W-1:0];
      np_n_r    <= c2_n_r;
      pp_n_r    <= np_r;
      pp_dp_r   <= dpw[NUM_W-1:0];
      pp_zero_r <= big;
    end
  end

  // ---------------- density division, one quotient bit per stage
  typedef struct packed {
    logic [NUM_W-1:0]  rem;
    logic [NUM_W-1:0]  dp;
    logic [QDEN_W-1:0] q;
    logic              sat;
    logic              zero;
  } qstage_t;

  qstage_t         qd_r [QDEN_W+1];
  logic [QDEN_W:0] qdv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qdv_r <= '0;
    end else if (adv) begin
      qdv_r <= {qdv_r[QDEN_W-1:0], pp_vld_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qd_r[0].rem  <= pp_n_r;
      qd_r[0].dp   <= pp_dp_r;
      qd_r[0].q    <= '0;
      qd_r[0].zero <= pp_zero_r;
      qd_r[0].sat  <= (pp_dp_r[NUM_W-1:28] == '0) &&
                      (pp_n_r >= {pp_dp_r[27:0], 32'b0});
    end
  end

  for (genvar j = 0; j < QDEN_W; j++) begin : g_qdiv
    localparam int K = QDEN_W - 1 - j;
    qstage_t            nx;
    logic [QWIDE_W-1:0] dk;

    always_comb begin
      nx = qd_r[j];
      dk = {{QDEN_W{1'b0}}, qd_r[j].dp} << K;
      if ({{QDEN_W{1'b0}}, qd_r[j].rem} >= dk) begin
        nx.rem  = qd_r[j].rem - dk[NUM_W-1:0];
        nx.q[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        qd_r[j+1] <= nx;
      end
    end
  end

  // ---------------- output register
  out_item_t res;

  always_comb begin
    res.saturated = qd_r[QDEN_W].sat && !qd_r[QDEN_W].zero;
    if (qd_r[QDEN_W].zero) begin
      res.density = '0;
    end else if (qd_r[QDEN_W].sat) begin
      res.density = '1;
    end else begin
      res.density = qd_r[QDEN_W].q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= qdv_r[QDEN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### hw/rtl/oriented_gaussian_field_value.sv
// Top level of the oriented Gaussian field value block: configuration registers,
// front stage, decoupling queue and arithmetic back end. Depends on ogf_pkg,
// ogf_front, ogf_fifo and ogf_back.
//
//   port group | direction | handshake           | payload
//   -----------+-----------+---------------------+-------------------------------
//   in_*       | request   | in_valid / in_stall | in_data  : query_x, query_y
//   out_*      | result    | out_valid/out_stall | out_data : density, saturated
//   cfg_*      | write     | cfg_we              | cfg_idx, cfg_wdata (no read-back)
//
// One request enters per cycle while in_stall is low; results leave one per cycle in
// request order while out_stall is low. Each request passes through the CORDIC stage
// chain and the bit-per-stage ratio and density dividers.
// Reset (rst_n, synchronous) clears all valid flags and loads the register defaults.
// An out_stall with out_valid high freezes the whole back end; the queue then
// absorbs requests until it fills, at which point in_stall rises.
`default_nettype none

module oriented_gaussian_field_value import ogf_pkg::*; #(
  parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
  parameter int EXP_TABLE_BITS = EXP_TABLE_BITS_DEF,
  parameter int FIFO_DEPTH     = FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t  cfg_r;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  work_t fr_item;
  work_t q_item;

  // Configuration registers; drop writes to unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.centre_x     <= 32'sd0;
      cfg_r.centre_y     <= 32'sd0;
      cfg_r.velocity_x   <= 32'sd65536;
      cfg_r.velocity_y   <= 32'sd0;
      cfg_r.sigma_along  <= 32'd65536;
      cfg_r.sigma_across <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_idx))
        REG_CENTRE_X:     cfg_r.centre_x     <= $signed(cfg_wdata);
        REG_CENTRE_Y:     cfg_r.centre_y     <= $signed(cfg_wdata);
        REG_VELOCITY_X:   cfg_r.velocity_x   <= $signed(cfg_wdata);
        REG_VELOCITY_Y:   cfg_r.velocity_y   <= $signed(cfg_wdata);
        REG_SIGMA_ALONG:  cfg_r.sigma_along  <= cfg_wdata;
        REG_SIGMA_ACROSS: cfg_r.sigma_across <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Offset the query and fold the heading into the right half plane
  ogf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (fr_item)
  );

  // Hold classified requests while the back end is frozen
  ogf_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (fr_item),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_item),
    .empty (q_empty)
  );

  // Rotate, square, exponentiate and divide
  ogf_back #(
    .CORDIC_STEPS   (CORDIC_STEPS),
    .EXP_TABLE_BITS (EXP_TABLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
